@@ src/cst_pkg.sv @@
`timescale 1ns / 1ps

package cst_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned SOCK_W  = 8;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned COUNT_W = 7;

  // Raw command codes as they arrive on the input channel.
  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE    = 3'd0,
    CMD_DELETE    = 3'd1,
    CMD_COUNT     = 3'd2,
    CMD_FIND_ID   = 3'd3,
    CMD_FIND_SOCK = 3'd4
  } cmd_e;

  // Classified operation handed from the front to the back.
  typedef enum logic [2:0] {
    OP_CREATE,
    OP_DELETE,
    OP_COUNT,
    OP_FIND_ID,
    OP_FIND_SOCK,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [MODE_W-1:0] mode;
    logic [SOCK_W-1:0] socket;
    logic [ID_W-1:0]   conn_id;
  } item_t;

endpackage

@@ src/cst_front.sv @@
`timescale 1ns / 1ps

module cst_front import cst_pkg::*; (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [SOCK_W-1:0] socket_i,
  input  logic [ID_W-1:0]   conn_id_i,
  input  logic              full_i,
  output logic              push_o,
  output item_t             item_o
);

  op_e op;

  // Codes outside the defined set become a no-op that reports failure.
  always_comb begin
    unique case (command_i)
      CMD_CREATE:    op = OP_CREATE;
      CMD_DELETE:    op = OP_DELETE;
      CMD_COUNT:     op = OP_COUNT;
      CMD_FIND_ID:   op = OP_FIND_ID;
      CMD_FIND_SOCK: op = OP_FIND_SOCK;
      default:       op = OP_NONE;
    endcase
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  assign item_o.op      = op;
  assign item_o.mode    = mode_i;
  assign item_o.socket  = socket_i;
  assign item_o.conn_id = conn_id_i;

endmodule

@@ src/cst_queue.sv @@
`timescale 1ns / 1ps

module cst_queue import cst_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  item_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  fill_q, fill_d;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ src/cst_back.sv @@
`timescale 1ns / 1ps

module cst_back import cst_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  item_t              item_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               status_o,
  output logic [ID_W-1:0]    found_id_o,
  output logic [SOCK_W-1:0]  found_socket_o,
  output logic [MODE_W-1:0]  found_mode_o,
  output logic [COUNT_W-1:0] live_count_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  // Slot storage. A slot is live when its bit in live_q is set; the payload
  // of a free slot is never looked at, so it needs no clearing.
  logic [MAX_ENTRIES-1:0] live_q;
  logic [ID_W-1:0]        id_q   [MAX_ENTRIES];
  logic [MODE_W-1:0]      mode_q [MAX_ENTRIES];
  logic [SOCK_W-1:0]      sock_q [MAX_ENTRIES];
  logic [ID_W-1:0]        next_id_q, next_id_d;
  logic [CNT_W-1:0]       cnt_q;

  logic [MAX_ENTRIES-1:0] free_vec, sock_hit, id_hit;
  logic [MAX_ENTRIES-1:0] first_free, first_sock, first_id;

  logic                   out_valid_q;
  logic                   status_q, status_d;
  logic [ID_W-1:0]        fid_q, fid_d;
  logic [SOCK_W-1:0]      fsock_q, fsock_d;
  logic [MODE_W-1:0]      fmode_q, fmode_d;
  logic [COUNT_W-1:0]     cnt_out_q, cnt_out_d;

  logic [ID_W-1:0]        sock_sel_id;
  logic [MODE_W-1:0]      sock_sel_mode;
  logic [SOCK_W-1:0]      id_sel_sock;
  logic [MODE_W-1:0]      id_sel_mode;

  logic do_create, do_delete;

  assign pop_o = !empty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      free_vec[i] = !live_q[i];
      sock_hit[i] = live_q[i] && (sock_q[i] == item_i.socket);
      id_hit[i]   = live_q[i] && (id_q[i] == item_i.conn_id);
    end
  end

  // Isolate the lowest set bit of each request vector.
  assign first_free = free_vec & (~free_vec + {{(MAX_ENTRIES-1){1'b0}}, 1'b1});
  assign first_sock = sock_hit & (~sock_hit + {{(MAX_ENTRIES-1){1'b0}}, 1'b1});
  assign first_id   = id_hit & (~id_hit + {{(MAX_ENTRIES-1){1'b0}}, 1'b1});

  // One-hot AND-OR selection of the matched slot's fields.
  always_comb begin
    sock_sel_id   = '0;
    sock_sel_mode = '0;
    id_sel_sock   = '0;
    id_sel_mode   = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      sock_sel_id   = sock_sel_id   | (id_q[i]   & {ID_W{first_sock[i]}});
      sock_sel_mode = sock_sel_mode | (mode_q[i] & {MODE_W{first_sock[i]}});
      id_sel_sock   = id_sel_sock   | (sock_q[i] & {SOCK_W{first_id[i]}});
      id_sel_mode   = id_sel_mode   | (mode_q[i] & {MODE_W{first_id[i]}});
    end
  end

  assign do_create = pop_o && (item_i.op == OP_CREATE) && (|free_vec);
  assign do_delete = pop_o && (item_i.op == OP_DELETE) && (|sock_hit);

  // The id counter skips zero when it wraps.
  assign next_id_d = (next_id_q == {ID_W{1'b1}}) ? {{(ID_W-1){1'b0}}, 1'b1}
                                                 : next_id_q + {{(ID_W-1){1'b0}}, 1'b1};

  always_comb begin
    status_d  = 1'b1;
    fid_d     = '0;
    fsock_d   = '0;
    fmode_d   = '0;
    cnt_out_d = '0;
    case (item_i.op)
      OP_CREATE: begin
        if (|free_vec) begin
          status_d = 1'b0;
          fid_d    = next_id_q;
        end
      end
      OP_DELETE: begin
        status_d = !(|sock_hit);
      end
      OP_COUNT: begin
        status_d  = 1'b0;
        cnt_out_d = COUNT_W'(cnt_q);
      end
      OP_FIND_ID: begin
        if (|sock_hit) begin
          status_d = 1'b0;
          fid_d    = sock_sel_id;
          fmode_d  = sock_sel_mode;
        end
      end
      OP_FIND_SOCK: begin
        if (|id_hit) begin
          status_d = 1'b0;
          fsock_d  = id_sel_sock;
          fmode_d  = id_sel_mode;
        end
      end
      default: begin
        status_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= '0;
      next_id_q   <= {{(ID_W-1){1'b0}}, 1'b1};
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (do_create) begin
        live_q    <= live_q | first_free;
        next_id_q <= next_id_d;
        cnt_q     <= cnt_q + CNT_W'(1);
      end else if (do_delete) begin
        live_q <= live_q & ~first_sock;
        cnt_q  <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_create) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (first_free[i]) begin
          id_q[i]   <= next_id_q;
          mode_q[i] <= item_i.mode;
          sock_q[i] <= item_i.socket;
        end
      end
    end
    if (pop_o) begin
      status_q  <= status_d;
      fid_q     <= fid_d;
      fsock_q   <= fsock_d;
      fmode_q   <= fmode_d;
      cnt_out_q <= cnt_out_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign found_id_o     = fid_q;
  assign found_socket_o = fsock_q;
  assign found_mode_o   = fmode_q;
  assign live_count_o   = cnt_out_q;

endmodule

@@ src/connection_slot_table.sv @@
`timescale 1ns / 1ps

// Connection slot table: MAX_ENTRIES slots (1 to 127) of id, mode and socket,
// held in flip-flops and searched in parallel. Create takes the lowest free
// slot and hands out the next id from a 16-bit counter that starts at 1 and
// skips 0 on wrap; delete frees the lowest live slot with a matching socket;
// count returns the number of live slots; the two lookups return the id or
// socket and the mode of the lowest live matching slot. Status is 0 on
// success and 1 when the table is full, nothing matches or the command code
// is undefined; fields that do not apply to a command read as 0. Each
// transaction produces exactly one result transaction. The block sustains one
// command per clock cycle while the output side is not stalled: the front
// decodes the command into a two-entry queue and the back executes one queued
// command per cycle against the table and registers its result. An accepted
// command waits in the queue while the output register holds a result that
// has not been taken, so a stall on the output side holds the queue. Reset
// empties the table at once; no clearing pass is needed.
module connection_slot_table import cst_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [SOCK_W-1:0]  socket_i,
  input  logic [ID_W-1:0]    conn_id_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               status_o,
  output logic [ID_W-1:0]    found_id_o,
  output logic [SOCK_W-1:0]  found_socket_o,
  output logic [MODE_W-1:0]  found_mode_o,
  output logic [COUNT_W-1:0] live_count_o
);

  // Decoded command travelling from the front into the queue and back out.
  item_t push_item;
  item_t pop_item;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;

  // The front classifies each accepted transaction and stalls the input
  // whenever the queue is full.
  cst_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .mode_i     (mode_i),
    .socket_i   (socket_i),
    .conn_id_i  (conn_id_i),
    .full_i     (full),
    .push_o     (push),
    .item_o     (push_item)
  );

  // The queue lets the input keep flowing while a result waits on the output.
  cst_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (empty)
  );

  // The back owns the table, the id counter and the live count, and pops a
  // command whenever its output register is empty or being drained.
  cst_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (pop_item),
    .empty_i        (empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .found_id_o     (found_id_o),
    .found_socket_o (found_socket_o),
    .found_mode_o   (found_mode_o),
    .live_count_o   (live_count_o)
  );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the connection slot table. A tracker object keeps
// its own copy of the slot table and the id counter, works out the reply for
// every command transaction the block accepts, and compares every reply
// transaction the block delivers against the oldest outstanding prediction.
module testbench import cst_pkg::*;;

  localparam int unsigned SLOTS      = 8;
  localparam int unsigned CYCLE_LIMIT = 100_000;

  // Command codes the block does not define; they must be answered with a
  // plain failure and leave the table untouched.
  localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

  // Sockets used to fill the table in the directed part. Two slots share the
  // all-ones socket so that lookups and delete must pick the lower slot.
  localparam logic [SOCK_W-1:0] FILL_SOCKETS [SLOTS] = '{
    8'h00, 8'hFF, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F
  };

  // A small pool of sockets keeps the random traffic colliding, so that
  // deletes and lookups hit live entries most of the time.
  localparam logic [SOCK_W-1:0] SOCKET_POOL [4] = '{8'h00, 8'h01, 8'hFE, 8'hFF};

  typedef struct packed {
    logic               status;
    logic [ID_W-1:0]    found_id;
    logic [SOCK_W-1:0]  found_socket;
    logic [MODE_W-1:0]  found_mode;
    logic [COUNT_W-1:0] live_count;
  } reply_t;

  // Tracks the table contents and the replies still owed by the block.
  class slot_table_tracker;
    logic [ID_W-1:0]   slot_id     [SLOTS];
    logic [MODE_W-1:0] slot_mode   [SLOTS];
    logic [SOCK_W-1:0] slot_socket [SLOTS];
    logic [ID_W-1:0]   next_id;
    reply_t            expected_replies [$];
    int                errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_id[i]     = '0;
        slot_mode[i]   = '0;
        slot_socket[i] = '0;
      end
      next_id = ID_W'(1);
      errors  = 0;
    endfunction

    // Applies one accepted command to the table copy and queues its reply.
    function void note_command(logic [CMD_W-1:0] cmd, logic [MODE_W-1:0] md,
                               logic [SOCK_W-1:0] sk, logic [ID_W-1:0] cid);
      reply_t r;
      bit     done;
      int     live;
      r        = '0;
      r.status = 1'b1;
      done     = 1'b0;
      live     = 0;
      case (cmd)
        CMD_CREATE: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!done && slot_id[i] == '0) begin
              slot_id[i]     = next_id;
              slot_mode[i]   = md;
              slot_socket[i] = sk;
              r.found_id     = next_id;
              r.status       = 1'b0;
              next_id        = next_id + ID_W'(1);
              if (next_id == '0) next_id = ID_W'(1);
              done = 1'b1;
            end
          end
        end
        CMD_DELETE: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!done && slot_id[i] != '0 && slot_socket[i] == sk) begin
              slot_id[i]     = '0;
              slot_mode[i]   = '0;
              slot_socket[i] = '0;
              r.status       = 1'b0;
              done = 1'b1;
            end
          end
        end
        CMD_COUNT: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_id[i] != '0) live++;
          end
          r.live_count = COUNT_W'(live);
          r.status     = 1'b0;
        end
        CMD_FIND_ID: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!done && slot_id[i] != '0 && slot_socket[i] == sk) begin
              r.found_id   = slot_id[i];
              r.found_mode = slot_mode[i];
              r.status     = 1'b0;
              done = 1'b1;
            end
          end
        end
        CMD_FIND_SOCK: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!done && slot_id[i] != '0 && slot_id[i] == cid) begin
              r.found_socket = slot_socket[i];
              r.found_mode   = slot_mode[i];
              r.status       = 1'b0;
              done = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      expected_replies.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        $error("reply transaction arrived with no command outstanding");
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.found_id !== want.found_id) begin
        $error("found_id mismatch: expected %0d, actual %0d", want.found_id, got.found_id);
        errors++;
      end
      if (got.found_socket !== want.found_socket) begin
        $error("found_socket mismatch: expected %0d, actual %0d",
               want.found_socket, got.found_socket);
        errors++;
      end
      if (got.found_mode !== want.found_mode) begin
        $error("found_mode mismatch: expected %0d, actual %0d",
               want.found_mode, got.found_mode);
        errors++;
      end
      if (got.live_count !== want.live_count) begin
        $error("live_count mismatch: expected %0d, actual %0d",
               want.live_count, got.live_count);
        errors++;
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // Id of a random slot; a free slot yields 0, which must never match.
    function logic [ID_W-1:0] pick_id();
      return slot_id[$urandom_range(SLOTS - 1)];
    endfunction
  endclass

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   command  = '0;
  logic [MODE_W-1:0]  mode     = '0;
  logic [SOCK_W-1:0]  socket   = '0;
  logic [ID_W-1:0]    conn_id  = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               status;
  logic [ID_W-1:0]    found_id;
  logic [SOCK_W-1:0]  found_socket;
  logic [MODE_W-1:0]  found_mode;
  logic [COUNT_W-1:0] live_count;

  // Percent chance per cycle that the sender holds off, and that the
  // receiver stalls. Each test phase sets both.
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned cycle_count        = 0;

  slot_table_tracker tracker = new();

  connection_slot_table #(
    .MAX_ENTRIES(SLOTS)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .mode_i         (mode),
    .socket_i       (socket),
    .conn_id_i      (conn_id),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .found_id_o     (found_id),
    .found_socket_o (found_socket),
    .found_mode_o   (found_mode),
    .live_count_o   (live_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The watchdog ends a hung run. The limit is many times the length of a
  // correct run, even with the longest sender gaps and receiver stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("connection_slot_table test failed");
      $finish;
    end
  end

  // Reply side. Outputs are sampled at the rising edge, before the block's
  // own updates land, and the stall for the next cycle is drawn at random.
  always @(posedge clk) begin
    reply_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.status       = status;
      got.found_id     = found_id;
      got.found_socket = found_socket;
      got.found_mode   = found_mode;
      got.live_count   = live_count;
      tracker.check_reply(got);
    end
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Offers one command transaction, after a random hold-off, and returns at
  // the edge that accepts it. Valid is left high, so back-to-back commands
  // need no extra cycle; a hold-off lowers it first.
  task automatic send(input logic [CMD_W-1:0] cmd, input logic [MODE_W-1:0] md,
                      input logic [SOCK_W-1:0] sk, input logic [ID_W-1:0] cid);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    mode     <= md;
    socket   <= sk;
    conn_id  <= cid;
    do @(posedge clk); while (in_stall);
    tracker.note_command(cmd, md, sk, cid);
  endtask

  // Stops offering commands until every reply has been delivered.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Random traffic. The mix alternates between create-heavy and
  // delete-heavy stretches so that the table swings between full and empty.
  task automatic send_random(input int count);
    logic [CMD_W-1:0]  cmd;
    logic [SOCK_W-1:0] sk;
    logic [ID_W-1:0]   cid;
    int unsigned       pick;
    int unsigned       create_w;
    for (int n = 0; n < count; n++) begin
      create_w = ((n / 40) % 2 == 0) ? 45 : 15;
      pick = $urandom_range(99);
      if (pick < create_w) cmd = CMD_CREATE;
      else if (pick < 60) cmd = CMD_DELETE;
      else if (pick < 70) cmd = CMD_COUNT;
      else if (pick < 83) cmd = CMD_FIND_ID;
      else if (pick < 95) cmd = CMD_FIND_SOCK;
      else cmd = CMD_W'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
      if ($urandom_range(9) < 7) sk = SOCKET_POOL[$urandom_range(3)];
      else sk = SOCK_W'($urandom_range(255));
      if ($urandom_range(9) < 7) cid = tracker.pick_id();
      else cid = ID_W'($urandom_range(16'hFFFF));
      send(cmd, MODE_W'($urandom_range(3)), sk, cid);
    end
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int count);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    send_random(count);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, without idling. An empty table first: count is zero and
    // every lookup or delete fails, including a lookup of id 0.
    send(CMD_COUNT, '0, '0, '0);
    send(CMD_FIND_ID, '0, 8'h00, '0);
    send(CMD_FIND_SOCK, '0, '0, 16'h0000);
    send(CMD_DELETE, '0, 8'h00, '0);
    // Fill every slot, with all modes and the socket extremes.
    for (int i = 0; i < SLOTS; i++) begin
      send(CMD_CREATE, MODE_W'(i), FILL_SOCKETS[i], 16'hFFFF);
    end
    // A create into a full table must fail and leave the counter alone.
    send(CMD_CREATE, 2'd3, 8'h42, '0);
    send(CMD_COUNT, '0, '0, '0);
    // The shared socket resolves to the lower slot.
    send(CMD_FIND_ID, '0, 8'hFF, '0);
    send(CMD_FIND_SOCK, '0, '0, 16'h0000);
    send(CMD_FIND_SOCK, '0, '0, 16'hFFFF);
    send(CMD_FIND_SOCK, '0, '0, 16'd3);
    // Deleting the shared socket frees only the lower slot.
    send(CMD_DELETE, '0, 8'hFF, '0);
    send(CMD_FIND_ID, '0, 8'hFF, '0);
    send(CMD_UNDEF_LO, '0, '0, '0);
    send(CMD_UNDEF_HI, 2'd3, 8'hFF, 16'hFFFF);
    // The freed slot is the lowest free one and gets reused.
    send(CMD_CREATE, 2'd3, 8'hFF, '0);
    send(CMD_COUNT, '0, '0, '0);

    run_phase(0, 0, 175);
    // The sender waits here until the block has answered everything.
    drain();
    repeat (4) @(posedge clk);
    run_phase(76, 0, 175);
    run_phase(0, 76, 175);
    run_phase(20, 20, 175);

    drain();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("connection_slot_table test passed");
    end else begin
      $display("connection_slot_table test failed");
    end
    $finish;
  end

endmodule
